// ----- rtl/double_ended_queue_top_macros.svh -----
// Assertion macros for the double-ended queue top level.
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define DQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("double-ended queue assertion failed");

// Next-cycle implication checked at every rising clock edge outside reset.
`define DQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("double-ended queue assertion failed");

`endif

// ----- rtl/dq_pkg.sv -----
// Package with the shared types and codes of the double-ended queue.
package dq_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ       = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic add_front;
    logic add_back;
    logic take_front;
    logic take_back;
    logic rd;
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic in_range;
  } dp_sts_t;

endpackage

// ----- rtl/dq_ctrl.sv -----
// Controller: handshake state machine and operation decode of the double-ended queue.
module dq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [2:0]       mode,
  input  dq_pkg::dp_sts_t  sts,
  output dq_pkg::ctl_cmd_t cmd,
  output logic [1:0]       status
);
  import dq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_RESULT = 2'b10
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t st_reg;
  status_t st_next;
  logic    load;

  assign out_valid = (state == S_RESULT);
  assign in_ready  = (state == S_IDLE) || out_ready;
  assign load      = in_valid && in_ready;
  assign status    = st_reg;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (load) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (load) begin
          state_next = S_RESULT;
        end else if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.load = load;
    st_next  = ST_OK;
    case (mode_t'(mode))
      MODE_PUSH_FRONT: begin
        if (sts.full) begin
          st_next = ST_FULL;
        end else begin
          cmd.add_front = load;
        end
      end
      MODE_PUSH_BACK: begin
        if (sts.full) begin
          st_next = ST_FULL;
        end else begin
          cmd.add_back = load;
        end
      end
      MODE_POP_FRONT: begin
        if (sts.empty) begin
          st_next = ST_EMPTY;
        end else begin
          cmd.take_front = load;
        end
      end
      MODE_POP_BACK: begin
        if (sts.empty) begin
          st_next = ST_EMPTY;
        end else begin
          cmd.take_back = load;
        end
      end
      MODE_READ: begin
        if (sts.in_range) begin
          cmd.rd = load;
        end else begin
          st_next = ST_RANGE;
        end
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      st_reg <= st_next;
    end
  end

endmodule

// ----- rtl/dq_dpath.sv -----
// Datapath: ring store, front pointer and occupancy of the double-ended queue.
module dq_dpath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  dq_pkg::ctl_cmd_t cmd,
  input  logic [31:0]      value,
  input  logic [3:0]       position,
  output dq_pkg::dp_sts_t  sts,
  output logic [31:0]      read_value,
  output logic [4:0]       count
);
  import dq_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PCW = (CW > 4) ? CW : 5;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  rd_ok;
  logic [AW-1:0]         front;
  logic [AW-1:0]         front_next;
  logic [CW-1:0]         occ;
  logic [CW-1:0]         occ_next;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  we;
  logic signed [63:0]    wide;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [AW-1:0] offs);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, offs};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  assign sts.full     = (occ == DEPTH_C);
  assign sts.empty    = (occ == '0);
  assign sts.in_range = (PCW'(position) < PCW'(occ));

  assign wdata = DATA_WIDTH'({32'd0, value});
  assign raddr = ring_add(front, AW'(position));
  assign we    = cmd.add_front || cmd.add_back;

  always_comb begin
    front_next = front;
    occ_next   = occ;
    waddr      = ring_add(front, AW'(occ));
    if (cmd.add_front) begin
      front_next = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
      waddr      = front_next;
      occ_next   = occ + CW'(1);
    end else if (cmd.add_back) begin
      occ_next = occ + CW'(1);
    end else if (cmd.take_front) begin
      front_next = ring_add(front, AW'(1));
      occ_next   = occ - CW'(1);
    end else if (cmd.take_back) begin
      occ_next = occ - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      occ   <= '0;
    end else begin
      front <= front_next;
      occ   <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.load) begin
      rd_data <= mem[raddr];
      rd_ok   <= cmd.rd;
    end
  end

  assign wide       = 64'(signed'(rd_data));
  assign read_value = rd_ok ? wide[31:0] : 32'd0;
  assign count      = 5'(occ);

endmodule

// ----- rtl/double_ended_queue_top.sv -----
// Top level of the bounded double-ended queue with ring storage.
// Usage:
//   The input channel (in_valid, in_ready) carries one transaction per
//   operation: mode selects push front, push back, pop front, pop back or
//   read at position; value is the word to push; position is the index
//   from the front for a read.
//   The output channel (out_valid, out_ready) returns exactly one result per
//   transaction: read_value, status and the count after the operation.
//   A result is valid in the cycle after its input transaction is
//   accepted. The store is a single memory with one write and one
//   registered read port, and that registered read sets the latency.
//   Throughput is one transaction per cycle while out_ready stays high.
//   When the receiver stalls, the result register holds and in_ready drops
//   until the result is taken; a new transaction may be accepted in the
//   same cycle as the waiting result leaves.
//   Reset empties the queue and clears the front pointer at once; the store
//   itself is not cleared, and no clearing pass is needed.
`include "double_ended_queue_top_macros.svh"

module double_ended_queue_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [31:0] value,
  input  logic [3:0]  position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_value,
  output logic [1:0]  status,
  output logic [4:0]  count
);
  import dq_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mode      (mode),
    .sts       (sts),
    .cmd       (cmd),
    .status    (status)
  );

  dq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value      (value),
    .position   (position),
    .sts        (sts),
    .read_value (read_value),
    .count      (count)
  );

  `DQ_ASSERT_NOW(a_full_not_empty, sts.full, !sts.empty)
  `DQ_ASSERT_NOW(a_stall_only_on_wait, !in_ready, out_valid && !out_ready)
  `DQ_ASSERT_NEXT(a_load_gives_result, cmd.load, out_valid)
  `DQ_ASSERT_NEXT(a_pop_decrements, cmd.take_front || cmd.take_back,
                  count == 5'($past(count) - 5'd1))

endmodule
